// ----- sv/wang_landau_sampler_step_core_assert.svh -----
// ----------------------------------------------------------------------------
// Wang-Landau step core assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WANG_LANDAU_SAMPLER_STEP_CORE_ASSERT_SVH
`define WANG_LANDAU_SAMPLER_STEP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked every clock outside reset
`define WLS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("wls assertion failed");

// condition that must never hold outside reset
`define WLS_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("wls forbidden condition");

`else

`define WLS_ASSERT(lbl, clk, rst, prop)
`define WLS_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- sv/wls_pkg.sv -----
// ----------------------------------------------------------------------------
// Wang-Landau step package
// State codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wls_pkg;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOVE,
      ST_SQN,
      ST_SUMN,
      ST_SUMC,
      ST_BINN,
      ST_BINC,
      ST_WIN,
      ST_RDC,
      ST_CMP,
      ST_PROB,
      ST_UPD,
      ST_HRD,
      ST_HINC,
      ST_WALK,
      ST_DIV,
      ST_FMUL,
      ST_FCMP,
      ST_HCLR,
      ST_READ,
      ST_RDAT,
      ST_OUT
   } state_type;

   localparam logic [1:0] CSR_FLATNESS  = 2'd0;
   localparam logic [1:0] CSR_STOP      = 2'd1;
   localparam logic [1:0] CSR_INTERVAL  = 2'd2;
   localparam logic [1:0] CSR_BINS      = 2'd3;

   localparam logic [8:0]  FLATNESS_RST = 9'd205;
   localparam logic [24:0] STOP_RST     = 25'd17;
   localparam logic [15:0] INTERVAL_RST = 16'd100;
   localparam logic [15:0] BINS_RST     = 16'd2621;
   localparam logic [24:0] LOGF_ONE     = 25'd16777216;
   localparam logic [47:0] ENT_MAX      = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] HIST_MAX     = 32'hFFFF_FFFF;

   // series terms of exp(-1/64) in Q62, each term the previous one over 64*n
   localparam logic [63:0] EXP_T0  = 64'd1 << 62;
   localparam logic [63:0] EXP_T1  = EXP_T0 / 64'd64;
   localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd128;
   localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd192;
   localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd256;
   localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd320;
   localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd384;
   localparam logic [63:0] EXP_T7  = EXP_T6 / 64'd448;
   localparam logic [63:0] EXP_T8  = EXP_T7 / 64'd512;
   localparam logic [63:0] EXP_T9  = EXP_T8 / 64'd576;
   localparam logic [63:0] EXP_T10 = EXP_T9 / 64'd640;
   localparam logic [63:0] EXP_T11 = EXP_T10 / 64'd704;
   localparam logic [63:0] EXP_T12 = EXP_T11 / 64'd768;
   localparam logic [63:0] EXP_T13 = EXP_T12 / 64'd832;
   localparam logic [63:0] EXP_T14 = EXP_T13 / 64'd896;
   localparam logic [63:0] EXP_T15 = EXP_T14 / 64'd960;
   localparam logic [63:0] EXP_T16 = EXP_T15 / 64'd1024;
   localparam logic [63:0] EXP_STEP = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                    - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                    + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13
                                    + EXP_T14 - EXP_T15 + EXP_T16;

   // floor(a * b / 2^62), operands below 2^63
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // round(65536 * exp(-k/64)) from a series for exp(-1/64) and repeated squaring
   function automatic logic [16:0] exp_prob(input logic [12:0] k);
      logic [63:0] c;
      logic [63:0] r;
      logic [63:0] s;
      c = EXP_STEP;
      r = 64'd1 << 62;
      for (int b = 0; b < 13; b++) begin
         if (k[b]) r = mul_q62(r, c);
         c = mul_q62(c, c);
      end
      s = (r + (64'd1 << 45)) >> 46;
      return s[16:0];
   endfunction

endpackage

// ----- sv/wang_landau_sampler_step_core.sv -----
// In window a step runs move, window test, compare and update; else it ends at the test.
// A flatness check adds a walk over all bins, a flat level a second pass that clears the histogram.
// Throughput: one item at a time; a new request waits until the last response is registered.
// Reset: synchronous; then a clearing pass over every bin zeroes both memories,
// during which req_ready is low. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Wang-Landau sampler step core
// One Wang-Landau move, or one entropy read, per item over entropy and visit-count memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wang_landau_sampler_step_core_assert.svh"

module wang_landau_sampler_step_core #(
   parameter int NUM_BINS        = 1024,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_rand_x_offset,
   input  logic [15:0] req_rand_x_scale,
   input  logic [15:0] req_rand_y_offset,
   input  logic [15:0] req_rand_y_scale,
   input  logic [15:0] req_rand_accept,
   input  logic [9:0]  req_read_bin,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_in_window,
   output logic        rsp_move_accepted,
   output logic        rsp_level_done,
   output logic        rsp_finished,
   output logic [9:0]  rsp_visited_bin,
   output logic [47:0] rsp_entropy_value,
   output logic [24:0] rsp_log_factor_now
);
   import wls_pkg::*;

   // NUM_BINS is a power of two: the mean count is the visit sum shifted down by BW
   localparam int BW = $clog2(NUM_BINS);
   localparam int EW = $clog2(EXP_TABLE_DEPTH);
   localparam int SW = 32 + BW;
   localparam logic [BW:0]   NB    = (BW + 1)'(NUM_BINS);
   localparam logic [BW:0]   NLAST = (BW + 1)'(NUM_BINS - 1);
   localparam logic [29:0]   KMAX  = 30'(EXP_TABLE_DEPTH);

   typedef logic [16:0] rom_type [EXP_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) t[i] = exp_prob(13'(i));
      return t;
   endfunction

   localparam rom_type EXP_ROM = build_rom();

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607) return 24'sh7FFFFF;
      if (v < -26'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic logic signed [23:0] moved(input logic signed [23:0] pos,
                                                input logic [15:0] off,
                                                input logic [15:0] scl);
      logic signed [16:0] o;
      logic signed [33:0] p;
      logic signed [17:0] d;
      o = $signed({1'b0, off}) - 17'sd32768;
      p = 34'(o) * $signed({18'd0, scl});
      d = 18'(p >>> 16);
      return sat24(26'(pos) + 26'(d));
   endfunction

   // memories
   logic [47:0] ent_mem [NUM_BINS];
   logic [31:0] hist_mem [NUM_BINS];
   logic [47:0] ent_rd_ff;
   logic [31:0] hist_rd_ff;
   logic [16:0] rom_rd_ff;
   logic [BW-1:0] ent_addr, hist_addr;
   logic [EW-1:0] rom_addr;
   logic          ent_we, hist_we;
   logic [47:0]   ent_wdata;
   logic [31:0]   hist_wdata;

   // configuration
   logic [8:0]  flat_ff;
   logic [24:0] stop_ff;
   logic [15:0] intv_ff;
   logic [15:0] bpe_ff;

   // control state
   state_type   state_ff, state_in;
   logic signed [23:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [24:0] lf_ff, lf_in;
   logic [15:0] icnt_ff, icnt_in;
   logic        done_ff, done_in;
   logic [BW:0] walk_ff, walk_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload and working registers
   logic        op_ff, op_in;
   logic [15:0] rxo_ff, rxo_in, rxs_ff, rxs_in, ryo_ff, ryo_in, rys_ff, rys_in;
   logic [15:0] racc_ff, racc_in;
   logic [9:0]  rbin_ff, rbin_in;
   logic signed [23:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [47:0] sqx_ff, sqx_in, sqy_ff, sqy_in, spn_ff, spn_in, spc_ff, spc_in;
   logic [63:0] prod_ff, prod_in;
   logic [22:0] bpn_ff, bpn_in;
   logic [BW-1:0] bc_ff, bc_in, bin_ff, bin_in;
   logic [47:0] sp_ff, sp_in, sc_ff, sc_in, ent_ff, ent_in;
   logic        gt_ff, gt_in, kbig_ff, kbig_in;
   logic        win_ff, win_in, acc_ff, acc_in, lvl_ff, lvl_in;
   logic [9:0]  vis_ff, vis_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [31:0] min_ff, min_in, quo_ff, quo_in;
   logic [40:0] fprod_ff, fprod_in;
   logic        o_win_ff, o_win_in, o_acc_ff, o_acc_in, o_lvl_ff, o_lvl_in;
   logic        o_fin_ff, o_fin_in;
   logic [9:0]  o_bin_ff, o_bin_in;
   logic [47:0] o_ent_ff, o_ent_in;
   logic [24:0] o_lf_ff, o_lf_in;

   always_comb begin
      logic signed [23:0] opx, opy;
      logic [23:0]        magx, magy;
      logic [47:0]        mula;
      logic [47:0]        diff, sel;
      logic [48:0]        esum;
      logic [16:0]        nxt;
      logic [15:0]        len;
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      lf_in        = lf_ff;
      icnt_in      = icnt_ff;
      done_in      = done_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in = op_ff;  rxo_in = rxo_ff;  rxs_in = rxs_ff;  ryo_in = ryo_ff;
      rys_in = rys_ff;  racc_in = racc_ff;  rbin_in = rbin_ff;
      nx_in = nx_ff;  ny_in = ny_ff;  sqx_in = sqx_ff;  sqy_in = sqy_ff;
      spn_in = spn_ff;  spc_in = spc_ff;  prod_in = prod_ff;  bpn_in = bpn_ff;
      bc_in = bc_ff;  bin_in = bin_ff;  sp_in = sp_ff;  sc_in = sc_ff;
      ent_in = ent_ff;  gt_in = gt_ff;  kbig_in = kbig_ff;
      win_in = win_ff;  acc_in = acc_ff;  lvl_in = lvl_ff;  vis_in = vis_ff;
      sum_in = sum_ff;  min_in = min_ff;  quo_in = quo_ff;
      fprod_in = fprod_ff;
      o_win_in = o_win_ff;  o_acc_in = o_acc_ff;  o_lvl_in = o_lvl_ff;
      o_fin_in = o_fin_ff;  o_bin_in = o_bin_ff;  o_ent_in = o_ent_ff;
      o_lf_in = o_lf_ff;
      ent_addr   = bin_ff;
      ent_we     = 1'b0;
      ent_wdata  = ent_ff;
      hist_addr  = bin_ff;
      hist_we    = 1'b0;
      hist_wdata = '0;
      diff       = sp_ff - ent_rd_ff;
      rom_addr   = diff[18 +: EW];
      req_ready  = 1'b0;
      opx        = (state_ff == ST_SQN) ? nx_ff : pos_x_ff;
      opy        = (state_ff == ST_SQN) ? ny_ff : pos_y_ff;
      // magnitudes; the most negative coordinate maps to 2^23 as unsigned
      magx       = opx[23] ? $unsigned(-opx) : $unsigned(opx);
      magy       = opy[23] ? $unsigned(-opy) : $unsigned(opy);
      mula       = (state_ff == ST_BINN) ? spn_ff : spc_ff;
      sel        = acc_ff ? sp_ff : sc_ff;
      esum       = '0;
      nxt        = {1'b0, icnt_ff} + 17'd1;
      len        = (intv_ff == 16'd0) ? 16'd1 : intv_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ent_addr   = walk_ff[BW-1:0];
            hist_addr  = walk_ff[BW-1:0];
            ent_we     = 1'b1;
            ent_wdata  = '0;
            hist_we    = 1'b1;
            walk_in    = walk_ff + 1'b1;
            if (walk_ff == NLAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_operation;  rxo_in = req_rand_x_offset;
               rxs_in = req_rand_x_scale;  ryo_in = req_rand_y_offset;
               rys_in = req_rand_y_scale;  racc_in = req_rand_accept;
               rbin_in = req_read_bin;
               win_in = 1'b0;  acc_in = 1'b0;  lvl_in = 1'b0;
               vis_in = '0;  ent_in = '0;
               if (req_operation) begin
                  state_in = ST_READ;
               end else if (done_ff || lf_ff <= stop_ff) begin
                  done_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MOVE;
               end
            end
         end
         ST_MOVE: begin
            nx_in    = moved(pos_x_ff, rxo_ff, rxs_ff);
            ny_in    = moved(pos_y_ff, ryo_ff, rys_ff);
            state_in = ST_SQN;
         end
         ST_SQN: begin
            sqx_in   = {24'd0, magx} * {24'd0, magx};
            sqy_in   = {24'd0, magy} * {24'd0, magy};
            state_in = ST_SUMN;
         end
         ST_SUMN: begin
            spn_in   = sqx_ff + sqy_ff;
            sqx_in   = {24'd0, magx} * {24'd0, magx};
            sqy_in   = {24'd0, magy} * {24'd0, magy};
            state_in = ST_SUMC;
         end
         ST_SUMC: begin
            spc_in   = sqx_ff + sqy_ff;
            state_in = ST_BINN;
         end
         ST_BINN: begin
            prod_in  = {16'd0, mula} * {48'd0, bpe_ff};
            state_in = ST_BINC;
         end
         ST_BINC: begin
            bpn_in   = prod_ff[63:41];
            prod_in  = {16'd0, mula} * {48'd0, bpe_ff};
            state_in = ST_WIN;
         end
         ST_WIN: begin
            bc_in    = (prod_ff[63:41] >= 23'(NUM_BINS)) ? NLAST[BW-1:0]
                                                         : prod_ff[41 +: BW];
            ent_addr = bpn_ff[BW-1:0];
            if (spn_ff != 48'd0 && bpn_ff < 23'(NUM_BINS)) begin
               win_in   = 1'b1;
               state_in = ST_RDC;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RDC: begin
            sp_in    = ent_rd_ff;
            ent_addr = bc_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // ent_rd_ff holds the current bin's entropy here
            sc_in    = ent_rd_ff;
            gt_in    = ent_rd_ff > sp_ff;
            kbig_in  = diff[47:18] >= KMAX;
            state_in = ST_PROB;
         end
         ST_PROB: begin
            acc_in   = gt_ff || (!kbig_ff && ({1'b0, racc_ff} < rom_rd_ff));
            state_in = ST_UPD;
         end
         ST_UPD: begin
            bin_in = acc_ff ? bpn_ff[BW-1:0] : bc_ff;
            vis_in = acc_ff ? 10'(bpn_ff[BW-1:0]) : 10'(bc_ff);
            esum   = {1'b0, sel} + {24'd0, lf_ff};
            ent_in = esum[48] ? ENT_MAX : esum[47:0];
            if (acc_ff) begin
               pos_x_in = nx_ff;
               pos_y_in = ny_ff;
            end
            state_in = ST_HRD;
         end
         ST_HRD: begin
            ent_we   = 1'b1;
            state_in = ST_HINC;
         end
         ST_HINC: begin
            // hist_rd_ff is the count read during the entropy write
            hist_we    = 1'b1;
            hist_wdata = (hist_rd_ff == HIST_MAX) ? HIST_MAX : hist_rd_ff + 32'd1;
            icnt_in    = (nxt >= {1'b0, len}) ? 16'd0 : nxt[15:0];
            if (icnt_ff == 16'd0) begin
               walk_in  = '0;
               sum_in   = '0;
               state_in = ST_WALK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_WALK: begin
            hist_addr = walk_ff[BW-1:0];
            walk_in   = walk_ff + 1'b1;
            if (walk_ff != '0) begin
               sum_in = sum_ff + SW'(hist_rd_ff);
               if (walk_ff == (BW + 1)'(1) || hist_rd_ff < min_ff) min_in = hist_rd_ff;
            end
            if (walk_ff == NB) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // floored mean count
            quo_in   = sum_ff[SW-1:BW];
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            fprod_in = {9'd0, quo_ff} * {32'd0, flat_ff};
            state_in = ST_FCMP;
         end
         ST_FCMP: begin
            if ({1'b0, min_ff, 8'd0} > fprod_ff) begin
               lvl_in  = 1'b1;
               lf_in   = {1'b0, lf_ff[24:1]};
               if ({1'b0, lf_ff[24:1]} <= stop_ff) done_in = 1'b1;
               walk_in = '0;
               state_in = ST_HCLR;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_HCLR: begin
            hist_addr = walk_ff[BW-1:0];
            hist_we   = 1'b1;
            walk_in   = walk_ff + 1'b1;
            if (walk_ff == NLAST) state_in = ST_OUT;
         end
         ST_READ: begin
            ent_addr = BW'(rbin_ff);
            state_in = ST_RDAT;
         end
         ST_RDAT: begin
            vis_in   = rbin_ff;
            ent_in   = (32'(rbin_ff) < 32'(NUM_BINS)) ? ent_rd_ff : 48'd0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_win_in = win_ff;  o_acc_in = acc_ff;  o_lvl_in = lvl_ff;
               o_fin_in = done_ff;  o_bin_in = vis_ff;  o_ent_in = ent_ff;
               o_lf_in  = lf_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         walk_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         lf_ff        <= LOGF_ONE;
         icnt_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flat_ff      <= FLATNESS_RST;
         stop_ff      <= STOP_RST;
         intv_ff      <= INTERVAL_RST;
         bpe_ff       <= BINS_RST;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         lf_ff        <= lf_in;
         icnt_ff      <= icnt_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FLATNESS: flat_ff <= csr_write_data[8:0];
               CSR_STOP:     stop_ff <= csr_write_data;
               CSR_INTERVAL: intv_ff <= csr_write_data[15:0];
               CSR_BINS:     bpe_ff  <= csr_write_data[15:0];
               default:      flat_ff <= flat_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;  rxo_ff <= rxo_in;  rxs_ff <= rxs_in;  ryo_ff <= ryo_in;
      rys_ff <= rys_in;  racc_ff <= racc_in;  rbin_ff <= rbin_in;
      nx_ff <= nx_in;  ny_ff <= ny_in;  sqx_ff <= sqx_in;  sqy_ff <= sqy_in;
      spn_ff <= spn_in;  spc_ff <= spc_in;  prod_ff <= prod_in;  bpn_ff <= bpn_in;
      bc_ff <= bc_in;  bin_ff <= bin_in;  sp_ff <= sp_in;  sc_ff <= sc_in;
      ent_ff <= ent_in;  gt_ff <= gt_in;  kbig_ff <= kbig_in;
      win_ff <= win_in;  acc_ff <= acc_in;  lvl_ff <= lvl_in;  vis_ff <= vis_in;
      sum_ff <= sum_in;  min_ff <= min_in;  quo_ff <= quo_in;
      fprod_ff <= fprod_in;
      o_win_ff <= o_win_in;  o_acc_ff <= o_acc_in;  o_lvl_ff <= o_lvl_in;
      o_fin_ff <= o_fin_in;  o_bin_ff <= o_bin_in;  o_ent_ff <= o_ent_in;
      o_lf_ff <= o_lf_in;
   end

   // entropy and histogram memories, exp table
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_addr] <= ent_wdata;
      ent_rd_ff <= ent_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_addr] <= hist_wdata;
      hist_rd_ff <= hist_mem[hist_addr];
   end

   always_ff @(posedge clock) begin
      rom_rd_ff <= EXP_ROM[rom_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_window      = o_win_ff;
   assign rsp_move_accepted  = o_acc_ff;
   assign rsp_level_done     = o_lvl_ff;
   assign rsp_finished       = o_fin_ff;
   assign rsp_visited_bin    = o_bin_ff;
   assign rsp_entropy_value  = o_ent_ff;
   assign rsp_log_factor_now = o_lf_ff;

   `WLS_ASSERT(a_done_sticks, clock, reset, done_ff |=> done_ff)
   `WLS_ASSERT(a_lf_no_rise, clock, reset, 1'b1 |=> lf_ff <= $past(lf_ff))
   `WLS_NEVER(a_acc_win, clock, reset, rsp_valid && rsp_move_accepted && !rsp_in_window)
   `WLS_NEVER(a_lvl_win, clock, reset, rsp_valid && rsp_level_done && !rsp_in_window)

endmodule
